FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk_i while out of reset
`define ASSERT_CK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CK(lbl, !(cond), msg)

`endif

FILE: rtl/core/mhst_pkg.sv
// ----------------------------------------------------------------------------
// Move history score table package
// Shared operation codes, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mhst_pkg;

  localparam int unsigned ScoreW = 16;
  localparam int unsigned LimitW = 15;
  localparam int unsigned DepthW = 8;
  localparam int unsigned SqrW   = 2 * DepthW;

  localparam logic [LimitW-1:0] LimitReset = 15'd16384;
  localparam logic [SqrW:0]     RewardCap  = 17'd800;
  localparam logic [SqrW-1:0]   PenaltyCap = 16'd400;

  // Operation codes of a transaction
  typedef enum logic [1:0] {
    OP_REWARD   = 2'd0,
    OP_PENALIZE = 2'd1,
    OP_HALVE    = 2'd2,
    OP_CLEAR    = 2'd3
  } mhst_op_e;

  // Table write source selected by the controller
  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_UPDATE = 2'd1,
    WR_HALVE  = 2'd2,
    WR_ZERO   = 2'd3
  } mhst_wr_e;

  // Controller to datapath commands
  typedef struct packed {
    logic     capture;
    logic     ptr_clr;
    logic     ptr_inc;
    logic     rd_sweep;
    mhst_wr_e wr_mode;
    logic     res_update;
    logic     res_zero;
  } mhst_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ptr_end;
    logic ptr_last;
  } mhst_sts_t;

endpackage

FILE: rtl/core/mhst_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhst_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/mhst_ctrl.sv
// ----------------------------------------------------------------------------
// Move history score table controller
// Sequences reset wipe, entry updates and table-wide halve/clear walks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mhst_ctrl
  import mhst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] operation_i,
  input  mhst_sts_t  sts_i,
  output mhst_cmd_t  cmd_o,
  output logic       busy_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_UPDATE,
    ST_HALVE,
    ST_CLEAR
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // Decode commands and next state
  always_comb begin
    state_d = state_q;
    cmd_o   = '{capture: 1'b0, ptr_clr: 1'b0, ptr_inc: 1'b0, rd_sweep: 1'b0,
                wr_mode: WR_NONE, res_update: 1'b0, res_zero: 1'b0};
    unique case (state_q)
      ST_INIT: begin
        cmd_o.wr_mode = WR_ZERO;
        cmd_o.ptr_inc = 1'b1;
        if (sts_i.ptr_last) begin
          cmd_o.ptr_clr = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          cmd_o.ptr_clr = 1'b1;
          unique case (mhst_op_e'(operation_i))
            OP_REWARD, OP_PENALIZE: state_d = ST_UPDATE;
            OP_HALVE:               state_d = ST_HALVE;
            OP_CLEAR:               state_d = ST_CLEAR;
            default:                state_d = ST_IDLE;
          endcase
        end
      end
      ST_UPDATE: begin
        cmd_o.wr_mode    = WR_UPDATE;
        cmd_o.res_update = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_HALVE: begin
        // read entry at pointer, write back the halved previous entry
        cmd_o.rd_sweep = 1'b1;
        cmd_o.wr_mode  = WR_HALVE;
        cmd_o.ptr_inc  = 1'b1;
        if (sts_i.ptr_end) begin
          cmd_o.ptr_clr  = 1'b1;
          cmd_o.res_zero = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        cmd_o.wr_mode = WR_ZERO;
        cmd_o.ptr_inc = 1'b1;
        if (sts_i.ptr_last) begin
          cmd_o.ptr_clr  = 1'b1;
          cmd_o.res_zero = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_CK(a_accept_goes_busy, accept |=> busy_o, "accepted transaction did not raise busy")
  `ASSERT_CK(a_halve_ends_idle, (state_q == ST_HALVE && sts_i.ptr_end) |=> (state_q == ST_IDLE),
             "halve walk did not return to idle")

endmodule

FILE: rtl/core/mhst_dpath.sv
// ----------------------------------------------------------------------------
// Move history score table datapath
// Score memory, walk pointer, update arithmetic and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mhst_dpath
  import mhst_pkg::*;
#(
  parameter int unsigned SQUARES = 64,
  parameter int unsigned SIDES   = 2,
  parameter int unsigned SQ_W    = 6,
  parameter int unsigned SIDE_W  = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mhst_cmd_t                cmd_i,
  output mhst_sts_t                sts_o,
  input  logic [1:0]               operation_i,
  input  logic [SIDE_W-1:0]        side_i,
  input  logic [SQ_W-1:0]          from_square_i,
  input  logic [SQ_W-1:0]          to_square_i,
  input  logic [DepthW-1:0]        depth_i,
  input  logic                     cfg_we_i,
  input  logic [LimitW-1:0]        cfg_wdata_i,
  output logic                     done_o,
  output logic signed [ScoreW-1:0] score_o
);

  localparam int unsigned AddrW = 2 * SQ_W + SIDE_W;
  localparam int unsigned Depth = 2 ** AddrW;
  localparam int unsigned SumW  = ScoreW + 2;

  localparam logic [AddrW:0]  PtrEnd    = {1'b1, {AddrW{1'b0}}};
  localparam logic [AddrW:0]  PtrLast   = {1'b0, {AddrW{1'b1}}};
  localparam logic [SQ_W:0]   SquareLim = (SQ_W + 1)'(SQUARES);
  localparam logic [SIDE_W:0] SideLim   = (SIDE_W + 1)'(SIDES);

  logic [AddrW:0]            ptr_q;
  logic [AddrW-1:0]          addr_q;
  logic                      in_range_q;
  logic                      reward_q;
  logic signed [SumW-1:0]    delta_q;
  logic [LimitW-1:0]         limit_q;
  logic                      done_q;
  logic signed [ScoreW-1:0]  score_q;

  logic [AddrW-1:0]          port_addr;
  logic                      in_range;
  logic [SqrW-1:0]           sqr;
  logic [SqrW:0]             bonus;
  logic [SqrW-1:0]           pen;
  logic signed [SumW-1:0]    delta;
  logic signed [ScoreW-1:0]  rdata;
  logic signed [SumW-1:0]    sum;
  logic signed [SumW-1:0]    lim_pos;
  logic signed [SumW-1:0]    lim_neg;
  logic signed [SumW-1:0]    upd_wide;
  logic signed [ScoreW-1:0]  upd_val;
  logic signed [ScoreW-1:0]  half_val;
  logic [AddrW:0]            ptr_m1;
  logic                      ram_re;
  logic [AddrW-1:0]          ram_raddr;
  logic                      ram_we;
  logic [AddrW-1:0]          ram_waddr;
  logic signed [ScoreW-1:0]  ram_wdata;

  // Form the entry address and range check from the ports
  assign port_addr = {from_square_i, to_square_i, side_i};
  assign in_range  = ({1'b0, from_square_i} < SquareLim) &&
                     ({1'b0, to_square_i} < SquareLim) &&
                     ({1'b0, side_i} < SideLim);

  // Size the signed step from depth
  assign sqr   = SqrW'(depth_i) * SqrW'(depth_i);
  assign bonus = ({sqr, 1'b0} > RewardCap) ? RewardCap : {sqr, 1'b0};
  assign pen   = (sqr > PenaltyCap) ? PenaltyCap : sqr;
  assign delta = (mhst_op_e'(operation_i) == OP_REWARD) ? SumW'(signed'({1'b0, bonus}))
                                                        : -SumW'(signed'({1'b0, pen}));

  // Capture the transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q     <= port_addr;
      in_range_q <= in_range;
      reward_q   <= (mhst_op_e'(operation_i) == OP_REWARD);
      delta_q    <= delta;
    end
  end

  // Hold the saturation limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Advance the walk pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      priority if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + 1'b1;
      end
    end
  end

  assign sts_o.ptr_end  = (ptr_q == PtrEnd);
  assign sts_o.ptr_last = (ptr_q == PtrLast);
  assign ptr_m1         = ptr_q - 1'b1;

  // Saturating update of the addressed entry
  assign sum      = SumW'(rdata) + delta_q;
  assign lim_pos  = SumW'(signed'({1'b0, limit_q}));
  assign lim_neg  = -lim_pos;
  always_comb begin
    if (reward_q) begin
      upd_wide = (sum > lim_pos) ? lim_pos : sum;
    end else begin
      upd_wide = (sum < lim_neg) ? lim_neg : sum;
    end
  end
  assign upd_val  = upd_wide[ScoreW-1:0];

  // Halve toward zero
  assign half_val = (rdata + signed'({{(ScoreW-1){1'b0}}, rdata[ScoreW-1]})) >>> 1;

  // Select table read
  assign ram_re    = cmd_i.capture || (cmd_i.rd_sweep && !ptr_q[AddrW]);
  assign ram_raddr = cmd_i.rd_sweep ? ptr_q[AddrW-1:0] : port_addr;

  // Select table write
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q[AddrW-1:0];
    ram_wdata = '0;
    unique case (cmd_i.wr_mode)
      WR_UPDATE: begin
        ram_we    = in_range_q;
        ram_waddr = addr_q;
        ram_wdata = upd_val;
      end
      WR_HALVE: begin
        ram_we    = (ptr_q != '0);
        ram_waddr = ptr_m1[AddrW-1:0];
        ram_wdata = half_val;
      end
      WR_ZERO: begin
        ram_we = 1'b1;
      end
      default: ram_we = 1'b0;
    endcase
  end

  mhst_ram #(
    .WIDTH (ScoreW),
    .DEPTH (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  // Register the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.res_update || cmd_i.res_zero;
    end
  end

  // Register the result value
  always_ff @(posedge clk_i) begin
    score_q <= (cmd_i.res_update && in_range_q) ? upd_val : '0;
  end

  assign done_o  = done_q;
  assign score_o = score_q;

  `ASSERT_CK(a_walk_result_zero, cmd_i.res_zero |=> (done_o && score_o == '0),
             "table-wide command returned a nonzero score")
  `ASSERT_NEVER(a_halve_no_overlap,
                ram_we && ram_re && cmd_i.rd_sweep && (ram_waddr == ram_raddr),
                "halve walk wrote and read the same entry")

endmodule

FILE: rtl/core/move_history_score_table_top.sv
// ----------------------------------------------------------------------------
// Move history score table
// Signed history scores per (from, to, side): reward, penalize, halve, clear.
// ----------------------------------------------------------------------------
//   channel   ports                                       direction
//   command   start_i, busy_o (out), operation_i,       in
//             side_i, from_square_i, to_square_i, depth_i
//   result    done_o, score_o                             out
//   config    cfg_we_i, cfg_wdata_i (score limit)         in
//
// Reward and penalize read the table when accepted, then do a read-modify-write
// in the update state, and done_o is registered after it; the next command may
// start the cycle done_o is high. Halve walks the score memory one entry per
// cycle through its single read and single write port; clear zeroes every
// entry. After reset a clearing pass runs with busy_o high.
// The receiver cannot stall; done_o lasts exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module move_history_score_table_top
  import mhst_pkg::*;
#(
  parameter int unsigned SQUARES = 64,
  parameter int unsigned SIDES   = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    operation_i,
  input  logic [((SIDES > 1) ? $clog2(SIDES) : 1)-1:0] side_i,
  input  logic [$clog2(SQUARES)-1:0]    from_square_i,
  input  logic [$clog2(SQUARES)-1:0]    to_square_i,
  input  logic [DepthW-1:0]             depth_i,
  input  logic                          cfg_we_i,
  input  logic [LimitW-1:0]             cfg_wdata_i,
  output logic                          done_o,
  output logic signed [ScoreW-1:0]      score_o
);

  localparam int unsigned SqW   = $clog2(SQUARES);
  localparam int unsigned SideW = (SIDES > 1) ? $clog2(SIDES) : 1;

  mhst_cmd_t cmd;
  mhst_sts_t sts;

  mhst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  mhst_dpath #(
    .SQUARES (SQUARES),
    .SIDES   (SIDES),
    .SQ_W    (SqW),
    .SIDE_W  (SideW)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (operation_i),
    .side_i        (side_i),
    .from_square_i (from_square_i),
    .to_square_i   (to_square_i),
    .depth_i       (depth_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .score_o       (score_o)
  );

  `ASSERT_CK(a_done_after_busy, done_o |-> $past(busy_o), "result strobe without a busy cycle")

endmodule

FILE: sim/mhst_score_check.sv
// ----------------------------------------------------------------------------
// Move history score table checker
// Watches the command, result and config ports, keeps a private copy of the
// score table and limit, and compares every result against the oldest
// outstanding expected score. Reports the outstanding count and failures.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhst_score_check
  import mhst_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  mhst_op_e                 op_i,
  input  logic                     side_i,
  input  logic [5:0]               from_i,
  input  logic [5:0]               to_i,
  input  logic [DepthW-1:0]        depth_i,
  input  logic                     cfg_we_i,
  input  logic [LimitW-1:0]        cfg_wdata_i,
  input  logic                     done_i,
  input  logic signed [ScoreW-1:0] score_i,
  output int                       pending_o,
  output int                       fail_count_o
);

  logic signed [ScoreW-1:0] history [0:8191];
  logic signed [ScoreW-1:0] expected_scores [$];
  int                       sat_limit;

  // Apply one transaction to the table copy and return the reported score
  function automatic logic signed [ScoreW-1:0] update_history(
    input mhst_op_e          op,
    input logic              side,
    input logic [5:0]        from_sq,
    input logic [5:0]        to_sq,
    input logic [DepthW-1:0] depth
  );
    int         sq;
    int         delta;
    int         v;
    int         i;
    logic [12:0] slot;
    sq   = int'(depth) * int'(depth);
    slot = {from_sq, to_sq, side};
    v    = 0;
    case (op)
      OP_REWARD: begin
        delta = (2 * sq > int'(RewardCap)) ? int'(RewardCap) : 2 * sq;
        v = int'(history[slot]) + delta;
        if (v > sat_limit) v = sat_limit;
        history[slot] = v[ScoreW-1:0];
      end
      OP_PENALIZE: begin
        delta = (sq > int'(PenaltyCap)) ? int'(PenaltyCap) : sq;
        v = int'(history[slot]) - delta;
        if (v < -sat_limit) v = -sat_limit;
        history[slot] = v[ScoreW-1:0];
      end
      OP_HALVE: begin
        // integer division truncates toward zero, as required
        for (i = 0; i < 8192; i++) history[i] = ScoreW'(int'(history[i]) / 2);
      end
      default: begin
        for (i = 0; i < 8192; i++) history[i] = '0;
      end
    endcase
    return v[ScoreW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [ScoreW-1:0] want;
    if (!rst_ni) begin
      for (int i = 0; i < 8192; i++) history[i] = '0;
      expected_scores.delete();
      sat_limit = int'(LimitReset);
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // Track limit writes
      if (cfg_we_i) sat_limit = int'(cfg_wdata_i);

      // Compare a result against the oldest outstanding score
      if (done_i) begin
        if (expected_scores.size() == 0) begin
          $error("score: unexpected result %0d", score_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_scores.pop_front();
          if (score_i !== want) begin
            $error("score: expected %0d, actual %0d", want, score_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end

      // Predict the accepted transaction
      if (start_i && !busy_i)
        expected_scores.push_back(update_history(op_i, side_i, from_i, to_i, depth_i));

      pending_o <= expected_scores.size();
    end
  end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// Move history score table testbench
// Drives a directed set of moves and whole-table commands, then random
// phases under several score limits with hot entries to reach saturation.
// The sender works in bursts with random gaps; the checker scores results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import mhst_pkg::*;

  localparam int ItemsPerPhase = 230;
  localparam int TableOpBudget = 7;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     start_i       = 1'b0;
  logic                     busy_o;
  mhst_op_e                 operation_i   = OP_REWARD;
  logic                     side_i        = 1'b0;
  logic [5:0]               from_square_i = '0;
  logic [5:0]               to_square_i   = '0;
  logic [DepthW-1:0]        depth_i       = '0;
  logic                     cfg_we_i      = 1'b0;
  logic [LimitW-1:0]        cfg_wdata_i   = '0;
  logic                     done_o;
  logic signed [ScoreW-1:0] score_o;

  int          pending_cnt;
  int          fail_cnt;
  int          burst_left;
  logic [12:0] hot_slots [0:3];
  int          hot_cnt;
  int          reward_pct;
  int          table_ops;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  move_history_score_table_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .operation_i  (operation_i),
    .side_i       (side_i),
    .from_square_i(from_square_i),
    .to_square_i  (to_square_i),
    .depth_i      (depth_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .done_o       (done_o),
    .score_o      (score_o)
  );

  mhst_score_check u_score_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .op_i        (operation_i),
    .side_i      (side_i),
    .from_i      (from_square_i),
    .to_i        (to_square_i),
    .depth_i     (depth_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_i      (done_o),
    .score_i     (score_o),
    .pending_o   (pending_cnt),
    .fail_count_o(fail_cnt)
  );

  // Drop start for a random gap, with junk on the fields
  task automatic end_burst();
    start_i       <= 1'b0;
    operation_i   <= mhst_op_e'($urandom_range(0, 3));
    side_i        <= 1'($urandom);
    from_square_i <= 6'($urandom);
    to_square_i   <= 6'($urandom);
    depth_i       <= 8'($urandom);
    repeat ($urandom_range(1, 8)) @(posedge clk_i);
    burst_left = $urandom_range(1, 40);
  endtask

  // Present one transaction and hold it until accepted
  task automatic push_move(
    input mhst_op_e          op,
    input logic              side,
    input logic [5:0]        from_sq,
    input logic [5:0]        to_sq,
    input logic [DepthW-1:0] depth
  );
    start_i       <= 1'b1;
    operation_i   <= op;
    side_i        <= side;
    from_square_i <= from_sq;
    to_square_i   <= to_sq;
    depth_i       <= depth;
    do @(posedge clk_i); while (busy_o);
    burst_left--;
    if (burst_left <= 0) end_burst();
  endtask

  // Write the score limit once the block has drained
  task automatic write_limit(input logic [LimitW-1:0] value);
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0 || busy_o);
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    burst_left = $urandom_range(1, 40);
  endtask

  // Pick hot entries and a reward/penalty bias for the next phase
  task automatic new_phase();
    int i;
    hot_cnt = $urandom_range(1, 4);
    for (i = 0; i < 4; i++) hot_slots[i] = 13'($urandom);
    reward_pct = $urandom_range(15, 85);
    table_ops  = 0;
  endtask

  // Issue one random transaction, mostly on the hot entries
  task automatic random_move();
    mhst_op_e          op;
    logic [12:0]       slot;
    logic [DepthW-1:0] depth;
    if (table_ops < TableOpBudget && $urandom_range(0, 999) < 25) begin
      op = ($urandom_range(0, 4) < 3) ? OP_HALVE : OP_CLEAR;
      table_ops++;
    end else begin
      op = ($urandom_range(0, 99) < reward_pct) ? OP_REWARD : OP_PENALIZE;
    end
    if ($urandom_range(0, 9) < 8) slot = hot_slots[$urandom_range(0, hot_cnt - 1)];
    else slot = 13'($urandom);
    case ($urandom_range(0, 7))
      0:       depth = '0;
      1:       depth = '1;
      2:       depth = 8'($urandom_range(18, 22));
      3, 4:    depth = 8'($urandom_range(0, 20));
      default: depth = 8'($urandom);
    endcase
    push_move(op, slot[0], slot[12:7], slot[6:1], depth);
  endtask

  initial begin
    int unsigned limit_plan [0:5];
    int          p;
    limit_plan = '{32767, 2500, 0, 1, 700, 0};
    burst_left = $urandom_range(1, 40);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: depth extremes, cap boundaries, truncation of halve, clear
    push_move(OP_REWARD,   1'b0, 6'd0,  6'd0,  8'd0);
    push_move(OP_REWARD,   1'b1, 6'd63, 6'd63, 8'd255);
    push_move(OP_REWARD,   1'b1, 6'd63, 6'd63, 8'd20);
    push_move(OP_REWARD,   1'b1, 6'd63, 6'd63, 8'd19);
    push_move(OP_PENALIZE, 1'b1, 6'd63, 6'd63, 8'd21);
    push_move(OP_PENALIZE, 1'b0, 6'd0,  6'd0,  8'd255);
    push_move(OP_PENALIZE, 1'b0, 6'd0,  6'd0,  8'd1);
    push_move(OP_HALVE,    1'b1, 6'd63, 6'd63, 8'd255);
    push_move(OP_REWARD,   1'b0, 6'd0,  6'd0,  8'd0);
    push_move(OP_PENALIZE, 1'b0, 6'd0,  6'd63, 8'd3);
    push_move(OP_HALVE,    1'b0, 6'd0,  6'd0,  8'd0);
    push_move(OP_REWARD,   1'b0, 6'd0,  6'd63, 8'd0);
    push_move(OP_REWARD,   1'b1, 6'd63, 6'd0,  8'd21);
    push_move(OP_CLEAR,    1'b1, 6'd63, 6'd63, 8'd255);
    push_move(OP_REWARD,   1'b1, 6'd63, 6'd63, 8'd0);
    push_move(OP_PENALIZE, 1'b0, 6'd42, 6'd21, 8'd128);
    push_move(OP_REWARD,   1'b1, 6'd21, 6'd42, 8'd1);

    // Random phase at the reset limit
    new_phase();
    repeat (ItemsPerPhase) random_move();

    // Random phases under new limits, without clearing between them
    for (p = 0; p < 6; p++) begin
      if (p == 5) write_limit(LimitW'($urandom_range(1, 32766)));
      else write_limit(LimitW'(limit_plan[p]));
      new_phase();
      repeat (ItemsPerPhase) random_move();
    end

    // Drain and report
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop on a hang
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
